FILE: design/cvh_pkg.sv
package cvh_pkg;

    localparam int MAX_POINTS = 64;
    localparam int COORD_BITS = 16;
    localparam int MIN_HULL   = 3;

    localparam int IDX_BITS  = $clog2(MAX_POINTS);
    localparam int CNT_BITS  = $clog2(MAX_POINTS + 1);
    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int PROD_BITS = 2 * DIFF_BITS;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic                         final_point;
    } point_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] hull_x;
        logic signed [COORD_BITS-1:0] hull_y;
        logic                         last_vertex;
        logic                         too_few;
        logic                         overflowed;
    } hull_t;

    typedef struct packed {
        logic done;
        logic ccw;
    } orient_t;

endpackage

FILE: design/cvh_orient.sv
module cvh_orient (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 go,
    input  logic signed [cvh_pkg::COORD_BITS-1:0] p_x,
    input  logic signed [cvh_pkg::COORD_BITS-1:0] p_y,
    input  logic signed [cvh_pkg::COORD_BITS-1:0] q_x,
    input  logic signed [cvh_pkg::COORD_BITS-1:0] q_y,
    input  logic signed [cvh_pkg::COORD_BITS-1:0] i_x,
    input  logic signed [cvh_pkg::COORD_BITS-1:0] i_y,
    output cvh_pkg::orient_t                      res
);
    import cvh_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SECOND,
        PH_DONE
    } phase_t;

    phase_t                       phase_reg;
    logic signed [DIFF_BITS-1:0] op_a;
    logic signed [DIFF_BITS-1:0] op_b;
    logic signed [PROD_BITS-1:0] prod;
    logic signed [PROD_BITS-1:0] a_reg;
    logic signed [PROD_BITS-1:0] b_reg;

    // first product (yi - yp) * (xq - xi), second (xi - xp) * (yq - yi)
    always_comb
    begin
        if (phase_reg == PH_SECOND)
        begin
            op_a = DIFF_BITS'(i_x) - DIFF_BITS'(p_x);
            op_b = DIFF_BITS'(q_y) - DIFF_BITS'(i_y);
        end
        else
        begin
            op_a = DIFF_BITS'(i_y) - DIFF_BITS'(p_y);
            op_b = DIFF_BITS'(q_x) - DIFF_BITS'(i_x);
        end
    end

    assign prod = op_a * op_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            a_reg     <= '0;
            b_reg     <= '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (go)
                    begin
                        a_reg     <= prod;
                        phase_reg <= PH_SECOND;
                    end
                end
                PH_SECOND:
                begin
                    b_reg     <= prod;
                    phase_reg <= PH_DONE;
                end
                PH_DONE:
                begin
                    phase_reg <= PH_IDLE;
                end
                default:
                begin
                    phase_reg <= PH_IDLE;
                end
            endcase
        end
    end

    assign res.done = (phase_reg == PH_DONE);
    assign res.ccw  = (a_reg < b_reg);

endmodule

FILE: design/convex_hull_gift_wrap.sv
// loading: one point beat per cycle until a set's final point is taken, then ready stays low
// walk: a leftmost search reads every point, then each hull vertex scans every point in turn,
// one at a time, set by the one shared multiplier and the single store read port
// emit: S_EMIT_V, S_EMIT_P, S_EMIT_OUT per hull beat, held until the output is free; one beat for a small set
// reset clears the sequencer and counters at once; the point store is never cleared
module convex_hull_gift_wrap (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             point_valid,
    output logic             point_ready,
    input  cvh_pkg::point_t  point,
    output logic             hull_valid,
    input  logic             hull_ready,
    output cvh_pkg::hull_t   hull
);
    import cvh_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD,
        S_FEW,
        S_MIN_RD,
        S_MIN_CHK,
        S_VTX,
        S_Q,
        S_SCAN_RD,
        S_SCAN_GO,
        S_SCAN_WAIT,
        S_STEP,
        S_EMIT_V,
        S_EMIT_P,
        S_EMIT_OUT
    } state_t;

    state_t                        state_reg;
    logic [CNT_BITS-1:0]           cnt_reg;
    logic                          dropped_reg;
    logic                          cut_reg;
    logic [CNT_BITS-1:0]           emitted_reg;
    logic [IDX_BITS-1:0]           i_reg;
    logic [IDX_BITS-1:0]           p_reg;
    logic [IDX_BITS-1:0]           q_reg;
    logic [IDX_BITS-1:0]           start_reg;
    logic [IDX_BITS-1:0]           k_reg;
    logic signed [COORD_BITS-1:0]  p_x_reg;
    logic signed [COORD_BITS-1:0]  p_y_reg;
    logic signed [COORD_BITS-1:0]  q_x_reg;
    logic signed [COORD_BITS-1:0]  q_y_reg;
    hull_t                         hull_reg;
    logic                          hull_valid_reg;

    logic signed [COORD_BITS-1:0]  store_x [MAX_POINTS];
    logic signed [COORD_BITS-1:0]  store_y [MAX_POINTS];
    logic [IDX_BITS-1:0]           vtx_mem [MAX_POINTS];
    logic signed [COORD_BITS-1:0]  rd_x_reg;
    logic signed [COORD_BITS-1:0]  rd_y_reg;
    logic [IDX_BITS-1:0]           vtx_rd_reg;

    logic                          accept;
    logic                          full;
    logic                          wr_en;
    logic                          rd_en;
    logic [IDX_BITS-1:0]           rd_addr;
    logic [CNT_BITS-1:0]           n_minus1;
    logic [IDX_BITS-1:0]           last_idx;
    logic [IDX_BITS-1:0]           p_succ;
    logic [CNT_BITS-1:0]           n_after;
    logic                          out_free;
    logic                          hull_load;
    logic                          emit_last;
    logic                          vtx_wr_en;
    orient_t                       orient;

    assign point_ready = (state_reg == S_LOAD);
    assign accept      = point_valid && point_ready;
    assign full        = (cnt_reg == CNT_BITS'(MAX_POINTS));
    assign wr_en       = accept && !full;
    assign n_minus1    = cnt_reg - CNT_BITS'(1);
    assign last_idx    = n_minus1[IDX_BITS-1:0];
    assign p_succ      = (p_reg == last_idx) ? '0 : p_reg + IDX_BITS'(1);
    assign n_after     = full ? cnt_reg : cnt_reg + CNT_BITS'(1);
    assign out_free    = !hull_valid_reg || hull_ready;
    assign hull_load   = ((state_reg == S_FEW) || (state_reg == S_EMIT_OUT)) && out_free;
    assign emit_last   = (CNT_BITS'(k_reg) + CNT_BITS'(1) == emitted_reg);
    assign vtx_wr_en   = (state_reg == S_VTX) && (emitted_reg != CNT_BITS'(MAX_POINTS));

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = i_reg;
        unique case (state_reg)
            S_MIN_RD, S_SCAN_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = i_reg;
            end
            S_VTX:
            begin
                rd_en   = 1'b1;
                rd_addr = p_succ;
            end
            S_EMIT_P:
            begin
                rd_en   = 1'b1;
                rd_addr = vtx_rd_reg;
            end
            default:
            begin
                rd_en   = 1'b0;
                rd_addr = i_reg;
            end
        endcase
    end

    // point store; the vertex list is in the block below
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_x[cnt_reg[IDX_BITS-1:0]] <= point.point_x;
            store_y[cnt_reg[IDX_BITS-1:0]] <= point.point_y;
        end
        if (rd_en)
        begin
            rd_x_reg <= store_x[rd_addr];
            rd_y_reg <= store_y[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (vtx_wr_en)
        begin
            vtx_mem[emitted_reg[IDX_BITS-1:0]] <= p_reg;
        end
        if (state_reg == S_EMIT_V)
        begin
            vtx_rd_reg <= vtx_mem[k_reg];
        end
    end

    cvh_orient u_orient (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (state_reg == S_SCAN_GO),
        .p_x   (p_x_reg),
        .p_y   (p_y_reg),
        .q_x   (q_x_reg),
        .q_y   (q_y_reg),
        .i_x   (rd_x_reg),
        .i_y   (rd_y_reg),
        .res   (orient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            cnt_reg        <= '0;
            dropped_reg    <= 1'b0;
            cut_reg        <= 1'b0;
            emitted_reg    <= '0;
            i_reg          <= '0;
            p_reg          <= '0;
            q_reg          <= '0;
            start_reg      <= '0;
            k_reg          <= '0;
            p_x_reg        <= '0;
            p_y_reg        <= '0;
            q_x_reg        <= '0;
            q_y_reg        <= '0;
            hull_reg       <= '0;
            hull_valid_reg <= 1'b0;
        end
        else
        begin
            if (hull_valid_reg && hull_ready && !hull_load)
            begin
                hull_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_LOAD:
                begin
                    if (accept)
                    begin
                        if (full)
                        begin
                            dropped_reg <= 1'b1;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + CNT_BITS'(1);
                        end
                        if (point.final_point)
                        begin
                            emitted_reg <= '0;
                            cut_reg     <= 1'b0;
                            i_reg       <= '0;
                            if (n_after < CNT_BITS'(MIN_HULL))
                            begin
                                state_reg <= S_FEW;
                            end
                            else
                            begin
                                state_reg <= S_MIN_RD;
                            end
                        end
                    end
                end
                S_FEW:
                begin
                    if (out_free)
                    begin
                        hull_reg.hull_x      <= '0;
                        hull_reg.hull_y      <= '0;
                        hull_reg.last_vertex <= 1'b1;
                        hull_reg.too_few     <= 1'b1;
                        hull_reg.overflowed  <= dropped_reg;
                        hull_valid_reg       <= 1'b1;
                        cnt_reg              <= '0;
                        dropped_reg          <= 1'b0;
                        state_reg            <= S_LOAD;
                    end
                end
                S_MIN_RD:
                begin
                    state_reg <= S_MIN_CHK;
                end
                // leftmost point, first one wins on ties
                S_MIN_CHK:
                begin
                    if (i_reg == '0 || rd_x_reg < p_x_reg)
                    begin
                        start_reg <= i_reg;
                        p_reg     <= i_reg;
                        p_x_reg   <= rd_x_reg;
                        p_y_reg   <= rd_y_reg;
                    end
                    if (i_reg == last_idx)
                    begin
                        state_reg <= S_VTX;
                    end
                    else
                    begin
                        i_reg     <= i_reg + IDX_BITS'(1);
                        state_reg <= S_MIN_RD;
                    end
                end
                S_VTX:
                begin
                    if (emitted_reg == CNT_BITS'(MAX_POINTS))
                    begin
                        cut_reg   <= 1'b1;
                        k_reg     <= '0;
                        state_reg <= S_EMIT_V;
                    end
                    else
                    begin
                        emitted_reg <= emitted_reg + CNT_BITS'(1);
                        q_reg       <= p_succ;
                        state_reg   <= S_Q;
                    end
                end
                S_Q:
                begin
                    q_x_reg   <= rd_x_reg;
                    q_y_reg   <= rd_y_reg;
                    i_reg     <= '0;
                    state_reg <= S_SCAN_RD;
                end
                S_SCAN_RD:
                begin
                    state_reg <= S_SCAN_GO;
                end
                S_SCAN_GO:
                begin
                    state_reg <= S_SCAN_WAIT;
                end
                S_SCAN_WAIT:
                begin
                    if (orient.done)
                    begin
                        if (orient.ccw)
                        begin
                            q_reg   <= i_reg;
                            q_x_reg <= rd_x_reg;
                            q_y_reg <= rd_y_reg;
                        end
                        if (i_reg == last_idx)
                        begin
                            state_reg <= S_STEP;
                        end
                        else
                        begin
                            i_reg     <= i_reg + IDX_BITS'(1);
                            state_reg <= S_SCAN_RD;
                        end
                    end
                end
                S_STEP:
                begin
                    p_reg   <= q_reg;
                    p_x_reg <= q_x_reg;
                    p_y_reg <= q_y_reg;
                    if (q_reg == start_reg)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_EMIT_V;
                    end
                    else
                    begin
                        state_reg <= S_VTX;
                    end
                end
                S_EMIT_V:
                begin
                    state_reg <= S_EMIT_P;
                end
                S_EMIT_P:
                begin
                    state_reg <= S_EMIT_OUT;
                end
                S_EMIT_OUT:
                begin
                    if (out_free)
                    begin
                        hull_reg.hull_x      <= rd_x_reg;
                        hull_reg.hull_y      <= rd_y_reg;
                        hull_reg.last_vertex <= emit_last;
                        hull_reg.too_few     <= 1'b0;
                        hull_reg.overflowed  <= dropped_reg | cut_reg;
                        hull_valid_reg       <= 1'b1;
                        if (emit_last)
                        begin
                            cnt_reg     <= '0;
                            dropped_reg <= 1'b0;
                            cut_reg     <= 1'b0;
                            state_reg   <= S_LOAD;
                        end
                        else
                        begin
                            k_reg     <= k_reg + IDX_BITS'(1);
                            state_reg <= S_EMIT_V;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign hull_valid = hull_valid_reg;
    assign hull       = hull_reg;

    a_few_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        hull_valid && hull.too_few |-> hull.last_vertex)
        else $error("small-set beat not marked last");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_BITS'(MAX_POINTS))
        else $error("point count beyond capacity");

    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        emitted_reg <= CNT_BITS'(MAX_POINTS))
        else $error("vertex count beyond capacity");

    a_final_busy: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && point_ready && point.final_point |=> !point_ready)
        else $error("input taken right after final point");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT_OUT |-> emitted_reg != '0)
        else $error("emit with empty vertex list");

endmodule

FILE: bench/convex_hull_gift_wrap_checker.sv
`timescale 1ns / 100ps

module convex_hull_gift_wrap_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            point_valid,
    input  logic            point_ready,
    input  cvh_pkg::point_t point,
    input  logic            hull_valid,
    input  logic            hull_ready,
    input  cvh_pkg::hull_t  hull,
    output int              mismatches,
    output int              pending,
    output int              hull_beats
);
    import cvh_pkg::*;

    logic signed [COORD_BITS-1:0] pts_x [MAX_POINTS];
    logic signed [COORD_BITS-1:0] pts_y [MAX_POINTS];
    int                           pts_held = 0;
    bit                           pts_dropped = 1'b0;
    hull_t                        expected_hull_q [$];
    hull_t                        want;
    int                           fail_total = 0;

    assign mismatches = fail_total;

    // exact sign of the cross product for the turn p -> i -> q
    function automatic bit turns_ccw(int p, int i, int q);
        longint lhs;
        longint rhs;
        lhs = (longint'(pts_y[i]) - longint'(pts_y[p]))
            * (longint'(pts_x[q]) - longint'(pts_x[i]));
        rhs = (longint'(pts_x[i]) - longint'(pts_x[p]))
            * (longint'(pts_y[q]) - longint'(pts_y[i]));
        return lhs < rhs;
    endfunction

    task automatic predict_hull();
        int    walk [MAX_POINTS];
        int    n;
        int    start;
        int    p;
        int    q;
        int    i;
        int    steps;
        bit    cut;
        bit    closed;
        hull_t vtx;
        n = pts_held;
        vtx = '0;
        if (n < MIN_HULL)
        begin
            vtx.last_vertex = 1'b1;
            vtx.too_few     = 1'b1;
            vtx.overflowed  = pts_dropped;
            expected_hull_q = {expected_hull_q, vtx};
        end
        else
        begin
            start = 0;
            for (i = 1; i < n; i++)
                if (pts_x[i] < pts_x[start])
                    start = i;
            steps  = 0;
            p      = start;
            cut    = 1'b0;
            closed = 1'b0;
            while (!closed && !cut)
            begin
                if (steps >= MAX_POINTS)
                    cut = 1'b1;
                else
                begin
                    walk[steps] = p;
                    steps++;
                    q = (p + 1) % n;
                    for (i = 0; i < n; i++)
                        if (turns_ccw(p, i, q))
                            q = i;
                    p = q;
                    closed = (p == start);
                end
            end
            for (i = 0; i < steps; i++)
            begin
                vtx.hull_x      = pts_x[walk[i]];
                vtx.hull_y      = pts_y[walk[i]];
                vtx.last_vertex = (i == steps - 1);
                vtx.too_few     = 1'b0;
                vtx.overflowed  = pts_dropped | cut;
                expected_hull_q = {expected_hull_q, vtx};
            end
        end
        pts_held    = 0;
        pts_dropped = 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_hull_q.delete();
            pts_held    = 0;
            pts_dropped = 1'b0;
            hull_beats <= 0;
            pending    <= 0;
        end
        else
        begin
            if (hull_valid && hull_ready)
            begin
                if (expected_hull_q.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("hull beat %0d with nothing expected: x=%0d y=%0d last=%0b",
                                 hull_beats, $signed(hull.hull_x), $signed(hull.hull_y),
                                 hull.last_vertex);
                end
                else
                begin
                    want = expected_hull_q.pop_front();
                    if (want.hull_x !== hull.hull_x || want.hull_y !== hull.hull_y
                        || want.last_vertex !== hull.last_vertex
                        || want.too_few !== hull.too_few
                        || want.overflowed !== hull.overflowed)
                    begin
                        fail_total++;
                        if (fail_total <= 10)
                        begin
                            $write("hull beat %0d: expected x=%0d y=%0d last=%0b few=%0b ovf=%0b",
                                   hull_beats, $signed(want.hull_x), $signed(want.hull_y),
                                   want.last_vertex, want.too_few, want.overflowed);
                            $display(", got x=%0d y=%0d last=%0b few=%0b ovf=%0b",
                                     $signed(hull.hull_x), $signed(hull.hull_y),
                                     hull.last_vertex, hull.too_few, hull.overflowed);
                        end
                    end
                end
                hull_beats <= hull_beats + 1;
            end
            if (point_valid && point_ready)
            begin
                if (pts_held < MAX_POINTS)
                begin
                    pts_x[pts_held] = point.point_x;
                    pts_y[pts_held] = point.point_y;
                    pts_held++;
                end
                else
                    pts_dropped = 1'b1;
                if (point.final_point)
                    predict_hull();
            end
            pending <= expected_hull_q.size();
        end
    end

endmodule

FILE: bench/convex_hull_gift_wrap_tb.sv
`timescale 1ns / 100ps

module convex_hull_gift_wrap_tb;
    import cvh_pkg::*;

    localparam int RANDOM_POINTS = 185;
    localparam int HOLD_AT_BEAT  = 6;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 300;
    localparam int CYCLE_LIMIT   = 2000000;

    typedef enum int {SPREAD_FULL, SPREAD_TIGHT, SPREAD_MID, SPREAD_EDGE} spread_t;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    point_valid;
    logic    point_ready;
    point_t  point;
    logic    hull_valid;
    logic    hull_ready;
    hull_t   hull;
    int      mismatches;
    int      pending;
    int      hull_beats;
    int      cycle_count = 0;
    int      points_sent = 0;
    int      sets_sent = 0;
    int      tx_calm = 0;
    int      rx_calm = 0;
    int      rx_taken = 0;
    int      rx_wait;
    int      random_sent = 0;
    int      set_idx = 0;
    int      set_size;
    int      k;
    spread_t spread;

    always #2 clk = ~clk;

    convex_hull_gift_wrap i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point       (point),
        .hull_valid  (hull_valid),
        .hull_ready  (hull_ready),
        .hull        (hull)
    );

    convex_hull_gift_wrap_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point       (point),
        .hull_valid  (hull_valid),
        .hull_ready  (hull_ready),
        .hull        (hull),
        .mismatches  (mismatches),
        .pending     (pending),
        .hull_beats  (hull_beats)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[convex_hull_gift_wrap] ERROR");
            $finish;
        end
    end

    // idle cycles before a beat, with runs of back-to-back beats
    function automatic int next_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            calm = $urandom_range(4, 16);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    function automatic logic signed [COORD_BITS-1:0] rand_coord(spread_t how);
        logic signed [COORD_BITS-1:0] c;
        case (how)
            SPREAD_FULL:  c = COORD_BITS'($urandom);
            SPREAD_TIGHT: c = COORD_BITS'($urandom_range(0, 15) - 8);
            SPREAD_MID:   c = COORD_BITS'($urandom_range(0, 2000) - 1000);
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       c = {1'b1, {(COORD_BITS-1){1'b0}}};
                    1:       c = {1'b0, {(COORD_BITS-1){1'b1}}};
                    2:       c = '0;
                    default: c = '1;
                endcase
            end
        endcase
        return c;
    endfunction

    task automatic drive_point(input int x, input int y, input logic fin);
        int     gap;
        point_t beat;
        gap = next_gap(tx_calm);
        if (gap != 0)
        begin
            point_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        beat.point_x     = COORD_BITS'(x);
        beat.point_y     = COORD_BITS'(y);
        beat.final_point = fin;
        point_valid <= 1'b1;
        point       <= beat;
        do @(posedge clk); while (!point_ready);
        points_sent++;
        if (fin)
            sets_sent++;
    endtask

    task automatic finish_hulls();
        point_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial
    begin
        hull_ready <= 1'b0;
        do @(posedge clk); while (rst_n !== 1'b1);
        forever
        begin
            rx_wait = next_gap(rx_calm);
            if (rx_wait != 0)
            begin
                hull_ready <= 1'b0;
                repeat (rx_wait) @(posedge clk);
            end
            hull_ready <= 1'b1;
            do @(posedge clk); while (!hull_valid);
            rx_taken++;
            // long stall so the block backs up onto the point channel
            if (rx_taken == HOLD_AT_BEAT)
            begin
                hull_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
        end
    end

    initial
    begin
        rst_n       <= 1'b0;
        point_valid <= 1'b0;
        point       <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // too few points: one, then two
        drive_point(-32768, 32767, 1'b1);
        drive_point(32767, -32768, 1'b0);
        drive_point(-1, 0, 1'b1);
        // full-range triangle
        drive_point(-32768, -32768, 1'b0);
        drive_point(32767, -32768, 1'b0);
        drive_point(0, 32767, 1'b1);
        // extreme square with an interior point
        drive_point(32767, 32767, 1'b0);
        drive_point(-32768, 32767, 1'b0);
        drive_point(-32768, -32768, 1'b0);
        drive_point(32767, -32768, 1'b0);
        drive_point(0, 0, 1'b1);
        // all collinear
        drive_point(0, 0, 1'b0);
        drive_point(1, 1, 1'b0);
        drive_point(2, 2, 1'b0);
        drive_point(3, 3, 1'b1);
        // repeated points
        drive_point(5, 5, 1'b0);
        drive_point(5, 5, 1'b0);
        drive_point(-5, -5, 1'b0);
        drive_point(5, 5, 1'b0);
        drive_point(-5, -5, 1'b0);
        drive_point(5, -5, 1'b1);
        finish_hulls();

        while (random_sent < RANDOM_POINTS)
        begin
            // one set runs past capacity, dropping points including the final one
            if (set_idx == 4)
                set_size = MAX_POINTS + 2;
            else if ($urandom_range(0, 7) == 0)
                set_size = $urandom_range(13, 30);
            else
                set_size = $urandom_range(1, 12);
            spread = spread_t'($urandom_range(0, 3));
            for (k = 0; k < set_size; k++)
                drive_point(rand_coord(spread), rand_coord(spread), k == set_size - 1);
            random_sent += set_size;
            set_idx++;
            if (set_idx == 10)
                finish_hulls();
        end
        finish_hulls();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d point beats in %0d sets, one set past capacity, others 1 to 30 points",
                 points_sent, sets_sent);
        $display("%0d hull beats compared, receiver held off %0d cycles once",
                 hull_beats, HOLD_CYCLES);
        if (mismatches == 0 && pending == 0)
            $display("[convex_hull_gift_wrap] OK");
        else
            $display("[convex_hull_gift_wrap] ERROR");
        $finish;
    end

endmodule
